FILE: sv/scrw_pkg.sv
// Shared types, codes and constants of the sensor control register writer.
// Used by the controller, the datapath, the divider and the top level.
package scrw_pkg;

	// command codes of an input item
	localparam logic [2:0] CMD_GAIN  = 3'd0;
	localparam logic [2:0] CMD_EXPO  = 3'd1;
	localparam logic [2:0] CMD_FRAME = 3'd2;
	localparam logic [2:0] CMD_HOLD  = 3'd3;
	localparam logic [2:0] CMD_MODE  = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_PCLK     = 3'd0;
	localparam logic [2:0] CFG_LLP      = 3'd1;
	localparam logic [2:0] CFG_GSCALE   = 3'd2;
	localparam logic [2:0] CFG_GMIN     = 3'd3;
	localparam logic [2:0] CFG_GMAX     = 3'd4;
	localparam logic [2:0] CFG_ESCALE   = 3'd5;
	localparam logic [2:0] CFG_FSCALE   = 3'd6;
	localparam logic [2:0] CFG_MODE     = 3'd7;
	localparam int         CFG_DATA_W   = 30;

	// sensor register addresses
	localparam logic [15:0] ADDR_EXP_HI  = 16'h3500;
	localparam logic [15:0] ADDR_EXP_MID = 16'h3501;
	localparam logic [15:0] ADDR_EXP_LO  = 16'h3502;
	localparam logic [15:0] ADDR_GAIN_HI = 16'h350a;
	localparam logic [15:0] ADDR_GAIN_LO = 16'h350b;
	localparam logic [15:0] ADDR_VTS_HI  = 16'h380e;
	localparam logic [15:0] ADDR_VTS_LO  = 16'h380f;
	localparam logic [15:0] ADDR_GROUP   = 16'h3208;

	// group hold data bytes
	localparam logic [7:0] HOLD_ENTER  = 8'h00;
	localparam logic [7:0] HOLD_EXIT   = 8'h10;
	localparam logic [7:0] HOLD_LAUNCH = 8'ha0;

	// limits
	localparam logic [63:0] GAIN_FLOOR = 64'd16;
	localparam logic [63:0] GAIN_CEIL  = 64'd1023;
	localparam logic [63:0] VTS_CEIL   = 64'hffff;
	localparam logic [63:0] EXP_FLOOR  = 64'd4;
	localparam logic [15:0] EXP_MARGIN = 16'd8;

	// configuration reset values
	localparam logic [7:0]  GSCALE_RST = 8'd16;
	localparam logic [15:0] GMIN_RST   = 16'd16;
	localparam logic [15:0] GMAX_RST   = 16'd1023;
	localparam logic [23:0] ESCALE_RST = 24'd1000000;
	localparam logic [23:0] FSCALE_RST = 24'd1000000;

	// divider sizes
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_D1_START,
		ST_D1_WAIT,
		ST_D2_START,
		ST_D2_WAIT,
		ST_CLAMP,
		ST_EMIT
	} scrw_state_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       decode;
		logic       mul;
		logic       div_start;
		logic       div_second;
		logic       clamp;
		logic [1:0] emit_idx;
	} scrw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       known;
		logic       bad;
		logic       div_done;
		logic       last;
	} scrw_stat_t;

	// minimum frame length of each sensor mode
	function automatic logic [15:0] mode_min(input logic [1:0] mode);
		logic [15:0] len;
		unique case (mode)
			2'd0: len = 16'd1968;
			2'd1: len = 16'd1104;
			2'd2: len = 16'd1435;
			2'd3: len = 16'd504;
			default: len = 16'd1968;
		endcase
		return len;
	endfunction

endpackage

FILE: sv/scrw_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
// Uses scrw_pkg for its sizes.
module scrw_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [scrw_pkg::DIV_N_W-1:0] dividend,
	input  logic [scrw_pkg::DIV_D_W-1:0] divisor,
	output logic                         done,
	output logic [scrw_pkg::DIV_N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(scrw_pkg::DIV_N_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(scrw_pkg::DIV_N_W - 1);

	logic                          run_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [scrw_pkg::DIV_N_W-1:0]  quo_q;
	logic [scrw_pkg::DIV_D_W-1:0]  rem_q;
	logic [scrw_pkg::DIV_D_W-1:0]  dvs_q;
	logic [scrw_pkg::DIV_D_W:0]    shifted;
	logic [scrw_pkg::DIV_D_W:0]    diff;
	logic                          ge;

	// one trial subtraction
	always_comb begin
		shifted = {rem_q, quo_q[scrw_pkg::DIV_N_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	// control: run flag, bit counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[scrw_pkg::DIV_N_W-2:0], ge};
			rem_q <= ge ? diff[scrw_pkg::DIV_D_W-1:0] : shifted[scrw_pkg::DIV_D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/scrw_dp.sv
// Datapath: configuration registers, kept frame length, multiplier, divider,
// clamping and result formatting. Uses scrw_pkg and scrw_div.
module scrw_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [scrw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [2:0]                     cmd,
	input  logic [31:0]                    value,
	input  scrw_pkg::scrw_cmd_t            ctl,
	output scrw_pkg::scrw_stat_t           stat,
	output logic [15:0]                    reg_addr,
	output logic [7:0]                     reg_data,
	output logic                           status
);

	logic [29:0] pclk_q;
	logic [15:0] llp_q;
	logic [7:0]  gscale_q;
	logic [15:0] gmin_q;
	logic [15:0] gmax_q;
	logic [23:0] escale_q;
	logic [23:0] fscale_q;
	logic [1:0]  mode_q;
	logic [15:0] fll_q;

	logic [2:0]  cmd_q;
	logic [31:0] val_q;
	logic        err_q;
	logic [63:0] acc_q;
	logic [15:0] res_q;

	logic        bad;
	logic        known;
	logic [15:0] gain_v;
	logic [15:0] mm;
	logic [31:0] mul_a;
	logic [29:0] mul_b;
	logic [61:0] prod;
	logic [31:0] dvs;
	logic        div_done;
	logic [63:0] quotient;
	logic [15:0] fll_eff;
	logic [15:0] maxc;
	logic [15:0] clamped;
	logic        last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pclk_q   <= '0;
			llp_q    <= '0;
			gscale_q <= scrw_pkg::GSCALE_RST;
			gmin_q   <= scrw_pkg::GMIN_RST;
			gmax_q   <= scrw_pkg::GMAX_RST;
			escale_q <= scrw_pkg::ESCALE_RST;
			fscale_q <= scrw_pkg::FSCALE_RST;
			mode_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scrw_pkg::CFG_PCLK:   pclk_q   <= cfg_data;
				scrw_pkg::CFG_LLP:    llp_q    <= cfg_data[15:0];
				scrw_pkg::CFG_GSCALE: gscale_q <= cfg_data[7:0];
				scrw_pkg::CFG_GMIN:   gmin_q   <= cfg_data[15:0];
				scrw_pkg::CFG_GMAX:   gmax_q   <= cfg_data[15:0];
				scrw_pkg::CFG_ESCALE: escale_q <= cfg_data[23:0];
				scrw_pkg::CFG_FSCALE: fscale_q <= cfg_data[23:0];
				scrw_pkg::CFG_MODE:   mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign mm = scrw_pkg::mode_min(mode_q);

	// divisor checks and gain input clamp (low test wins)
	always_comb begin
		known = 1'b1;
		bad   = 1'b0;
		unique case (cmd_q)
			scrw_pkg::CMD_GAIN:  bad = (gscale_q == '0);
			scrw_pkg::CMD_EXPO:  bad = (escale_q == '0) || (llp_q == '0);
			scrw_pkg::CMD_FRAME: bad = (val_q == '0) || (llp_q == '0);
			scrw_pkg::CMD_HOLD,
			scrw_pkg::CMD_MODE:  bad = 1'b0;
			default:             known = 1'b0;
		endcase
		if (val_q < {16'd0, gmin_q})
			gain_v = gmin_q;
		else if (val_q > {16'd0, gmax_q})
			gain_v = gmax_q;
		else
			gain_v = val_q[15:0];
	end

	// multiplier operands: exposure uses value*pclk, frame rate pclk*scale
	always_comb begin
		if (cmd_q == scrw_pkg::CMD_EXPO) begin
			mul_a = val_q;
			mul_b = pclk_q;
		end else begin
			mul_a = {2'b00, pclk_q};
			mul_b = {6'd0, fscale_q};
		end
		prod = mul_a * mul_b;
	end

	// divisor of the first or second division
	always_comb begin
		dvs = {16'd0, llp_q};
		unique case (cmd_q)
			scrw_pkg::CMD_GAIN:  dvs = {24'd0, gscale_q};
			scrw_pkg::CMD_EXPO:  dvs = ctl.div_second ? {16'd0, llp_q} : {8'd0, escale_q};
			scrw_pkg::CMD_FRAME: dvs = ctl.div_second ? val_q : {16'd0, llp_q};
			default:             dvs = {16'd0, llp_q};
		endcase
	end

	scrw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (acc_q),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quotient)
	);

	// final clamps of the quotient
	always_comb begin
		fll_eff = (fll_q == '0) ? mm : fll_q;
		maxc    = (fll_eff >= scrw_pkg::EXP_MARGIN) ? fll_eff - scrw_pkg::EXP_MARGIN : '0;
		clamped = acc_q[15:0];
		unique case (cmd_q)
			scrw_pkg::CMD_GAIN: begin
				if (acc_q < scrw_pkg::GAIN_FLOOR)
					clamped = scrw_pkg::GAIN_FLOOR[15:0];
				else if (acc_q > scrw_pkg::GAIN_CEIL)
					clamped = scrw_pkg::GAIN_CEIL[15:0];
			end
			scrw_pkg::CMD_EXPO: begin
				if (acc_q < scrw_pkg::EXP_FLOOR)
					clamped = scrw_pkg::EXP_FLOOR[15:0];
				else if (acc_q > {48'd0, maxc})
					clamped = maxc;
			end
			scrw_pkg::CMD_FRAME: begin
				if (acc_q < {48'd0, mm})
					clamped = mm;
				else if (acc_q > scrw_pkg::VTS_CEIL)
					clamped = scrw_pkg::VTS_CEIL[15:0];
			end
			default: clamped = acc_q[15:0];
		endcase
	end

	// kept frame length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fll_q <= '0;
		end else if (ctl.decode && !bad && cmd_q == scrw_pkg::CMD_MODE) begin
			fll_q <= mm;
		end else if (ctl.clamp && cmd_q == scrw_pkg::CMD_EXPO) begin
			fll_q <= fll_eff;
		end else if (ctl.clamp && cmd_q == scrw_pkg::CMD_FRAME) begin
			fll_q <= clamped;
		end
	end

	// item registers and working value
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= cmd;
			val_q <= value;
		end
		if (ctl.decode) begin
			err_q <= bad;
			acc_q <= {44'd0, gain_v, 4'd0};
			res_q <= mm;
		end else if (ctl.mul) begin
			acc_q <= {2'b00, prod};
		end else if (div_done) begin
			acc_q <= quotient;
		end else if (ctl.clamp) begin
			res_q <= clamped;
		end
	end

	// result formatting
	always_comb begin
		reg_addr = '0;
		reg_data = '0;
		last     = 1'b1;
		if (!err_q) begin
			unique case (cmd_q)
				scrw_pkg::CMD_GAIN: begin
					last = (ctl.emit_idx == 2'd1);
					if (ctl.emit_idx == 2'd0) begin
						reg_addr = scrw_pkg::ADDR_GAIN_HI;
						reg_data = {6'd0, res_q[9:8]};
					end else begin
						reg_addr = scrw_pkg::ADDR_GAIN_LO;
						reg_data = res_q[7:0];
					end
				end
				scrw_pkg::CMD_EXPO: begin
					last = (ctl.emit_idx == 2'd2);
					unique case (ctl.emit_idx)
						2'd0: begin
							reg_addr = scrw_pkg::ADDR_EXP_HI;
							reg_data = {4'd0, res_q[15:12]};
						end
						2'd1: begin
							reg_addr = scrw_pkg::ADDR_EXP_MID;
							reg_data = res_q[11:4];
						end
						default: begin
							reg_addr = scrw_pkg::ADDR_EXP_LO;
							reg_data = {res_q[3:0], 4'd0};
						end
					endcase
				end
				scrw_pkg::CMD_FRAME,
				scrw_pkg::CMD_MODE: begin
					last = (ctl.emit_idx == 2'd1);
					if (ctl.emit_idx == 2'd0) begin
						reg_addr = scrw_pkg::ADDR_VTS_HI;
						reg_data = res_q[15:8];
					end else begin
						reg_addr = scrw_pkg::ADDR_VTS_LO;
						reg_data = res_q[7:0];
					end
				end
				scrw_pkg::CMD_HOLD: begin
					reg_addr = scrw_pkg::ADDR_GROUP;
					if (val_q != '0) begin
						last     = 1'b1;
						reg_data = scrw_pkg::HOLD_ENTER;
					end else begin
						last     = (ctl.emit_idx == 2'd1);
						reg_data = (ctl.emit_idx == 2'd0) ? scrw_pkg::HOLD_EXIT
						                                  : scrw_pkg::HOLD_LAUNCH;
					end
				end
				default: last = 1'b1;
			endcase
		end
	end

	assign status        = err_q;
	assign stat.cmd      = cmd_q;
	assign stat.known    = known;
	assign stat.bad      = bad;
	assign stat.div_done = div_done;
	assign stat.last     = last;

endmodule

FILE: sv/scrw_ctrl.sv
// Controller state machine: sequences decode, multiply, up to two divisions,
// clamp and result emission, skipping the steps a command does not need. Uses scrw_pkg.
module scrw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  scrw_pkg::scrw_stat_t stat,
	output scrw_pkg::scrw_cmd_t  ctl
);

	scrw_pkg::scrw_state_t state_q, state_nx;
	logic [1:0]            idx_q;
	logic                  out_take;

	assign out_take = (state_q == scrw_pkg::ST_EMIT) && !out_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			scrw_pkg::ST_IDLE: begin
				if (in_valid)
					state_nx = scrw_pkg::ST_DECODE;
			end
			scrw_pkg::ST_DECODE: begin
				priority if (!stat.known)
					state_nx = scrw_pkg::ST_IDLE;
				else if (stat.bad)
					state_nx = scrw_pkg::ST_EMIT;
				else if (stat.cmd == scrw_pkg::CMD_GAIN)
					state_nx = scrw_pkg::ST_D2_START;
				else if (stat.cmd == scrw_pkg::CMD_EXPO || stat.cmd == scrw_pkg::CMD_FRAME)
					state_nx = scrw_pkg::ST_MUL;
				else
					state_nx = scrw_pkg::ST_EMIT;
			end
			scrw_pkg::ST_MUL:      state_nx = scrw_pkg::ST_D1_START;
			scrw_pkg::ST_D1_START: state_nx = scrw_pkg::ST_D1_WAIT;
			scrw_pkg::ST_D1_WAIT: begin
				if (stat.div_done)
					state_nx = scrw_pkg::ST_D2_START;
			end
			scrw_pkg::ST_D2_START: state_nx = scrw_pkg::ST_D2_WAIT;
			scrw_pkg::ST_D2_WAIT: begin
				if (stat.div_done)
					state_nx = scrw_pkg::ST_CLAMP;
			end
			scrw_pkg::ST_CLAMP:    state_nx = scrw_pkg::ST_EMIT;
			scrw_pkg::ST_EMIT: begin
				if (out_take && stat.last)
					state_nx = scrw_pkg::ST_IDLE;
			end
			default: state_nx = scrw_pkg::ST_IDLE;
		endcase
	end

	// datapath commands and handshake outputs
	always_comb begin
		ctl.capture    = (state_q == scrw_pkg::ST_IDLE) && in_valid;
		ctl.decode     = (state_q == scrw_pkg::ST_DECODE);
		ctl.mul        = (state_q == scrw_pkg::ST_MUL);
		ctl.div_start  = (state_q == scrw_pkg::ST_D1_START) ||
		                 (state_q == scrw_pkg::ST_D2_START);
		ctl.div_second = (state_q == scrw_pkg::ST_D2_START);
		ctl.clamp      = (state_q == scrw_pkg::ST_CLAMP);
		ctl.emit_idx   = idx_q;
		in_stall       = (state_q != scrw_pkg::ST_IDLE);
		out_valid      = (state_q == scrw_pkg::ST_EMIT);
	end

	// state and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scrw_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == scrw_pkg::ST_IDLE)
				idx_q <= '0;
			else if (out_take && !stat.last)
				idx_q <= idx_q + 1'b1;
		end
	end

endmodule

FILE: sv/sensor_control_register_writer_top.sv
// Sensor control register writer: camera commands in, register writes out.
// Exposure and frame rate take one multiply, then two divisions on the shared
// bit-serial divider; gain takes a single division. One item at a time: the next
// item is taken the cycle after the last result leaves.
// Reset (arst_n low, asynchronous) restores configuration defaults and clears
// the kept frame length.
module sensor_control_register_writer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [scrw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      cmd,
	input  logic [31:0]                     value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     reg_addr,
	output logic [7:0]                      reg_data,
	output logic                            status,
	output logic                            last
);

	scrw_pkg::scrw_cmd_t  ctl;
	scrw_pkg::scrw_stat_t stat;

	scrw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	scrw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.value     (value),
		.ctl       (ctl),
		.stat      (stat),
		.reg_addr  (reg_addr),
		.reg_data  (reg_data),
		.status    (status)
	);

	assign last = stat.last;

endmodule

FILE: sv/scrw_checker.sv
// Port-level checker for the sensor control register writer, with its bind.
// Depends only on the top level's ports.
module scrw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] reg_addr,
	input logic [7:0]  reg_data,
	input logic        status,
	input logic        last
);

	// no result is offered while a new item can be taken
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("result offered while input open");

	// an accepted item closes the input for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after accept");

	// an error result is the only result of its item
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && reg_addr == 16'd0 && reg_data == 8'd0)
		else $error("error result not final or not zero");

	// results of one item follow back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a result burst");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reg_addr) && $stable(reg_data))
		else $error("stalled result changed");

endmodule

bind sensor_control_register_writer_top scrw_checker u_scrw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.reg_addr  (reg_addr),
	.reg_data  (reg_data),
	.status    (status),
	.last      (last)
);

FILE: bench/sensor_control_register_writer_top_tb.sv
// Self-checking bench for sensor_control_register_writer_top: directed and random
// camera commands, register writes predicted in-bench and checked in order.
// Depends on scrw_pkg for command codes, register indexes and sensor addresses.
`timescale 1ns / 100ps

module sensor_control_register_writer_top_tb;

	// one sensor register write as it leaves the block
	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  data;
		logic        status;
		logic        last;
	} reg_write_t;

	localparam int HANG_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 200;

	// minimum frame length per sensor mode
	localparam logic [15:0] MODE_LINES [4] = '{16'd1968, 16'd1104, 16'd1435, 16'd504};

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [2:0]                      cfg_index = scrw_pkg::CFG_PCLK;
	logic [scrw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic [2:0]                      cmd       = scrw_pkg::CMD_GAIN;
	logic [31:0]                     value     = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [15:0]                     reg_addr;
	logic [7:0]                      reg_data;
	logic                            status;
	logic                            last;

	// shadow of the configuration and the kept frame length
	logic [29:0] pix_clk     = '0;
	logic [15:0] line_len    = '0;
	logic [7:0]  gain_scale  = scrw_pkg::GSCALE_RST;
	logic [15:0] gain_min    = scrw_pkg::GMIN_RST;
	logic [15:0] gain_max    = scrw_pkg::GMAX_RST;
	logic [23:0] expo_scale  = scrw_pkg::ESCALE_RST;
	logic [23:0] frame_scale = scrw_pkg::FSCALE_RST;
	logic [1:0]  sensor_sel  = '0;
	logic [15:0] kept_lines  = '0;

	reg_write_t expected_writes[$];
	int         mismatch_count = 0;
	int         quiet_cycles   = 0;
	int         send_gap_pct   = 0;
	int         recv_stall_pct = 0;
	logic       calm           = 1'b0;
	int         calm_count     = 0;

	sensor_control_register_writer_top dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .cmd, .value,
		.out_valid, .out_stall, .reg_addr, .reg_data, .status, .last
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// random stretches in which neither side idles
	always @(posedge clk) begin
		if (calm_count == 0) begin
			calm       <= ($urandom_range(3) == 0);
			calm_count <= 39;
		end else begin
			calm_count <= calm_count - 1;
		end
	end

	// receiver stall
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < recv_stall_pct);
	end

	// hang watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// compare each write leaving the block against the oldest prediction
	always @(posedge clk) begin
		reg_write_t want;
		if (out_valid && !out_stall) begin
			if (expected_writes.size() == 0) begin
				report_mismatch("unexpected write, addr", 32'(reg_addr), 32'd0);
			end else begin
				want = expected_writes.pop_front();
				if (reg_addr !== want.addr)
					report_mismatch("reg_addr", 32'(reg_addr), 32'(want.addr));
				if (reg_data !== want.data)
					report_mismatch("reg_data", 32'(reg_data), 32'(want.data));
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	function automatic void push_write(input logic [15:0] addr, input logic [7:0] data,
			input logic fin);
		expected_writes.push_back('{addr: addr, data: data, status: 1'b0, last: fin});
	endfunction

	function automatic void push_error();
		expected_writes.push_back('{addr: 16'd0, data: 8'd0, status: 1'b1, last: 1'b1});
	endfunction

	// register writes caused by one command, at the current configuration
	function automatic void predict_writes(input logic [2:0] op, input logic [31:0] val);
		logic [63:0] v;
		logic [63:0] q;
		logic [63:0] lim;
		case (op)
			scrw_pkg::CMD_GAIN: begin
				if (gain_scale == 0) begin
					push_error();
				end else begin
					v = 64'(val);
					if (v < gain_min) v = 64'(gain_min);
					else if (v > gain_max) v = 64'(gain_max);
					q = v * 64'd16 / gain_scale;
					if (q < scrw_pkg::GAIN_FLOOR) q = scrw_pkg::GAIN_FLOOR;
					else if (q > scrw_pkg::GAIN_CEIL) q = scrw_pkg::GAIN_CEIL;
					push_write(scrw_pkg::ADDR_GAIN_HI, {6'd0, q[9:8]}, 1'b0);
					push_write(scrw_pkg::ADDR_GAIN_LO, q[7:0], 1'b1);
				end
			end
			scrw_pkg::CMD_EXPO: begin
				if (expo_scale == 0 || line_len == 0) begin
					push_error();
				end else begin
					// an unset frame length falls back to the mode minimum
					if (kept_lines == 0) kept_lines = MODE_LINES[sensor_sel];
					if (kept_lines >= scrw_pkg::EXP_MARGIN)
						lim = 64'(kept_lines - scrw_pkg::EXP_MARGIN);
					else
						lim = 64'd0;
					q = 64'(val);
					q = q * pix_clk / expo_scale / line_len;
					if (q < scrw_pkg::EXP_FLOOR) q = scrw_pkg::EXP_FLOOR;
					else if (q > lim) q = lim;
					push_write(scrw_pkg::ADDR_EXP_HI, {4'd0, q[15:12]}, 1'b0);
					push_write(scrw_pkg::ADDR_EXP_MID, q[11:4], 1'b0);
					push_write(scrw_pkg::ADDR_EXP_LO, {q[3:0], 4'd0}, 1'b1);
				end
			end
			scrw_pkg::CMD_FRAME: begin
				if (val == 0 || line_len == 0) begin
					push_error();
				end else begin
					q = 64'(pix_clk);
					q = q * frame_scale / line_len / val;
					lim = 64'(MODE_LINES[sensor_sel]);
					if (q < lim) q = lim;
					else if (q > scrw_pkg::VTS_CEIL) q = scrw_pkg::VTS_CEIL;
					push_write(scrw_pkg::ADDR_VTS_HI, q[15:8], 1'b0);
					push_write(scrw_pkg::ADDR_VTS_LO, q[7:0], 1'b1);
					kept_lines = q[15:0];
				end
			end
			scrw_pkg::CMD_HOLD: begin
				if (val != 0) begin
					push_write(scrw_pkg::ADDR_GROUP, scrw_pkg::HOLD_ENTER, 1'b1);
				end else begin
					push_write(scrw_pkg::ADDR_GROUP, scrw_pkg::HOLD_EXIT, 1'b0);
					push_write(scrw_pkg::ADDR_GROUP, scrw_pkg::HOLD_LAUNCH, 1'b1);
				end
			end
			scrw_pkg::CMD_MODE: begin
				kept_lines = MODE_LINES[sensor_sel];
				push_write(scrw_pkg::ADDR_VTS_HI, kept_lines[15:8], 1'b0);
				push_write(scrw_pkg::ADDR_VTS_LO, kept_lines[7:0], 1'b1);
			end
			default: ;
		endcase
	endfunction

	// offer one item, optionally after a gap, and predict it once accepted;
	// valid stays high so a following item goes out back to back
	task automatic send_item(input logic [2:0] op, input logic [31:0] val);
		while (!calm && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		value    <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_writes(op, val);
	endtask

	// let every expected write arrive, then give an ignored item time to finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [29:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			scrw_pkg::CFG_PCLK:   pix_clk     = data;
			scrw_pkg::CFG_LLP:    line_len    = data[15:0];
			scrw_pkg::CFG_GSCALE: gain_scale  = data[7:0];
			scrw_pkg::CFG_GMIN:   gain_min    = data[15:0];
			scrw_pkg::CFG_GMAX:   gain_max    = data[15:0];
			scrw_pkg::CFG_ESCALE: expo_scale  = data[23:0];
			scrw_pkg::CFG_FSCALE: frame_scale = data[23:0];
			scrw_pkg::CFG_MODE:   sensor_sel  = data[1:0];
			default: ;
		endcase
	endtask

	// writes every register; only called with the block idle
	task automatic configure(input logic [29:0] pclk, input logic [15:0] llp,
			input logic [7:0] gscale, input logic [15:0] gmin, input logic [15:0] gmax,
			input logic [23:0] escale, input logic [23:0] fscale, input logic [1:0] msel);
		cfg_write(scrw_pkg::CFG_PCLK, pclk);
		cfg_write(scrw_pkg::CFG_LLP, 30'(llp));
		cfg_write(scrw_pkg::CFG_GSCALE, 30'(gscale));
		cfg_write(scrw_pkg::CFG_GMIN, 30'(gmin));
		cfg_write(scrw_pkg::CFG_GMAX, 30'(gmax));
		cfg_write(scrw_pkg::CFG_ESCALE, 30'(escale));
		cfg_write(scrw_pkg::CFG_FSCALE, 30'(fscale));
		cfg_write(scrw_pkg::CFG_MODE, 30'(msel));
		cfg_we <= 1'b0;
	endtask

	task automatic configure_typical();
		wait_idle();
		configure(30'($urandom_range(100_000_000, 20_000_000)),
			16'($urandom_range(3000, 1500)),
			8'($urandom_range(64, 1)), 16'($urandom_range(64, 0)),
			16'($urandom_range(4000, 500)),
			$urandom_range(1) ? 24'd1000000 : 24'($urandom_range(2_000_000, 100_000)),
			$urandom_range(1) ? 24'd1000000 : 24'($urandom_range(2_000_000, 100_000)),
			2'($urandom_range(3, 0)));
	endtask

	task automatic set_idling(input int gap_pct, input int stall_pct);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
	endtask

	// control value shaped for the command, with zeros and full-width noise
	function automatic logic [31:0] pick_value(input logic [2:0] op);
		logic [31:0] v;
		case ($urandom_range(15))
			0:       v = 32'd0;
			1, 2:    v = $urandom;
			default: begin
				case (op)
					scrw_pkg::CMD_GAIN:  v = $urandom_range(5000, 0);
					scrw_pkg::CMD_EXPO:  v = $urandom_range(200_000, 0);
					scrw_pkg::CMD_FRAME: v = $urandom_range(200_000_000, 1_000_000);
					scrw_pkg::CMD_HOLD:  v = $urandom_range(1, 0);
					default:             v = $urandom;
				endcase
			end
		endcase
		return v;
	endfunction

	// group-hold batch with random controls inside; the exit is sometimes dropped
	task automatic send_batch(inout int sent);
		logic [2:0] op;
		int         n;
		n = $urandom_range(3, 1);
		send_item(scrw_pkg::CMD_HOLD, $urandom_range(32'hffffffff, 1));
		repeat (n) begin
			op = 3'($urandom_range(scrw_pkg::CMD_FRAME, scrw_pkg::CMD_GAIN));
			send_item(op, pick_value(op));
		end
		sent += n + 1;
		if ($urandom_range(7) != 0) begin
			send_item(scrw_pkg::CMD_HOLD, 32'd0);
			sent++;
		end
	endtask

	task automatic test_random_traffic(input int count);
		logic [2:0] op;
		int         sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) < 6) begin
				send_batch(sent);
			end else begin
				if ($urandom_range(15) == 0)
					op = scrw_pkg::CMD_MODE + 3'($urandom_range(3, 1));
				else
					op = 3'($urandom_range(scrw_pkg::CMD_MODE, scrw_pkg::CMD_GAIN));
				send_item(op, pick_value(op));
				if (op <= scrw_pkg::CMD_MODE) sent++;
			end
		end
	endtask

	// defaults after reset: no pixel clock or line length yet
	task automatic test_reset_defaults();
		send_item(scrw_pkg::CMD_GAIN, 32'd0);
		send_item(scrw_pkg::CMD_GAIN, 32'hffffffff);
		send_item(scrw_pkg::CMD_GAIN, 32'd500);
		send_item(scrw_pkg::CMD_EXPO, 32'd1000);
		send_item(scrw_pkg::CMD_FRAME, 32'd30);
		send_item(scrw_pkg::CMD_HOLD, 32'd1);
		send_item(scrw_pkg::CMD_HOLD, 32'd0);
		send_item(scrw_pkg::CMD_MODE + 3'd1, 32'd0);
		send_item(scrw_pkg::CMD_MODE + 3'd3, 32'hffffffff);
	endtask

	// first valid exposure with no frame length set yet
	task automatic test_unset_length();
		wait_idle();
		configure(30'd80_000_000, 16'd2500, 8'd16, 16'd16, 16'd1023,
			24'd1000000, 24'd1000000, 2'd1);
		send_item(scrw_pkg::CMD_EXPO, 32'd10000);
		send_item(scrw_pkg::CMD_EXPO, 32'hffffffff);
		send_item(scrw_pkg::CMD_EXPO, 32'd0);
	endtask

	// frame length clamps, saturation, mode length and exposure bound
	task automatic test_frame_and_mode();
		send_item(scrw_pkg::CMD_FRAME, 32'd0);
		send_item(scrw_pkg::CMD_FRAME, 32'd1);
		send_item(scrw_pkg::CMD_EXPO, 32'hffffffff);
		send_item(scrw_pkg::CMD_FRAME, 32'd30_000_000);
		send_item(scrw_pkg::CMD_FRAME, 32'd10_000_000);
		send_item(scrw_pkg::CMD_MODE, 32'd7);
		send_item(scrw_pkg::CMD_EXPO, 32'd100_000);
	endtask

	// zero gain and exposure scale factors
	task automatic test_bad_divisors();
		wait_idle();
		configure(30'd50_000_000, 16'd2000, 8'd0, 16'd16, 16'd1023,
			24'd0, 24'd1000000, 2'd0);
		send_item(scrw_pkg::CMD_GAIN, 32'd100);
		send_item(scrw_pkg::CMD_EXPO, 32'd5000);
		send_item(scrw_pkg::CMD_FRAME, 32'd25_000_000);
	endtask

	// largest products and smallest divisors: most quotients saturate
	task automatic test_saturation();
		wait_idle();
		configure(30'd1_000_000_000, 16'd1, 8'd1, 16'd0, 16'hffff,
			24'd1, 24'hffffff, 2'd3);
		test_random_traffic(20);
	endtask

	// inverted gain limits, widest divisors, zero clock and rate factor
	task automatic test_inverted_limits();
		wait_idle();
		configure(30'd0, 16'hffff, 8'hff, 16'hffff, 16'd0,
			24'hffffff, 24'd0, 2'd2);
		test_random_traffic(20);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		set_idling(8, 87);
		test_reset_defaults();
		test_unset_length();
		test_frame_and_mode();
		test_bad_divisors();
		configure_typical();
		test_random_traffic(70);
		test_saturation();

		set_idling(87, 8);
		configure_typical();
		test_random_traffic(60);
		test_inverted_limits();

		set_idling(0, 0);
		configure_typical();
		test_random_traffic(50);

		wait_idle();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
sv/scrw_pkg.sv
sv/scrw_div.sv
sv/scrw_dp.sv
sv/scrw_ctrl.sv
sv/sensor_control_register_writer_top.sv
sv/scrw_checker.sv
bench/sensor_control_register_writer_top_tb.sv
